### hdl/timer_noise_sound_generator_defines.svh
// Assertion macros shared by the sound generator RTL.
// Included by the modules that carry concurrent assertions.
`ifndef TIMER_NOISE_SOUND_GENERATOR_DEFINES_SVH
`define TIMER_NOISE_SOUND_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define TNSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TNSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TNSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define TNSG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/tnsg_pkg.sv
// Package for the timer and noise sound generator: types, codes, constants, the
// volume table and the single-clock timer step function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tnsg_pkg;

    localparam int ACC_BITS = 24;
    localparam int STEP_BITS = ACC_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(STEP_BITS + 1);
    localparam logic [14:0] BASE_VOL = 15'(32767 / 6);

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_TIMER   = 2'd1;
    localparam logic [1:0] CMD_DIVIDER = 2'd2;
    localparam logic [1:0] CMD_EFFECTS = 2'd3;

    localparam logic [2:0] DIV_OFF_ENABLE = 3'd3;
    localparam logic [2:0] FX_OFF_CONTROL = 3'd0;
    localparam logic [2:0] TMR_OFF_CTRL02 = 3'd0;
    localparam logic [2:0] TMR_OFF_CTRL1  = 3'd1;

    localparam logic REG_FRAC  = 1'b0;
    localparam logic REG_MUSIC = 1'b1;

    localparam int TC_HOLD   = 0;
    localparam int TC_ECLK   = 1;
    localparam int TC_DUAL8  = 2;
    localparam int TC_NOLOAD = 4;
    localparam int TC_OUTEN  = 7;

    typedef struct packed {
        logic [15:0] cnt;
        logic        out;
        logic        rise;
    } tmr_res_t;

    typedef struct packed {
        logic        busy;
        logic        done;
    } div_stat_t;

    // Volume for a 3-bit level: floor(level * BASE_VOL / 7).
    function automatic logic [12:0] vol_of(input logic [2:0] lvl);
        logic [12:0] v;
        unique case (lvl)
            3'd0: v = 13'd0;
            3'd1: v = 13'd780;
            3'd2: v = 13'd1560;
            3'd3: v = 13'd2340;
            3'd4: v = 13'd3120;
            3'd5: v = 13'd3900;
            3'd6: v = 13'd4680;
            default: v = 13'd5461;
        endcase
        return v;
    endfunction

    // One timer channel advanced by at most one clock.
    function automatic tmr_res_t tmr_step(input logic [7:0] ctrl, input logic [15:0] cnt,
                                          input logic [15:0] lat, input logic out,
                                          input logic n);
        tmr_res_t r;
        logic [7:0] hi;
        r.cnt  = cnt;
        r.out  = out;
        r.rise = 1'b0;
        hi     = cnt[15:8] - 8'd1;
        if (n) begin
            if (ctrl[TC_DUAL8]) begin
                if (cnt[7:0] != 8'd0) begin
                    r.cnt = {cnt[15:8], cnt[7:0] - 8'd1};
                end else if (cnt[15:8] == 8'd0) begin
                    r.out = 1'b0;
                    r.cnt = lat;
                end else begin
                    r.cnt = {hi, lat[7:0]};
                    if (hi == 8'd0) begin
                        r.out  = 1'b1;
                        r.rise = 1'b1;
                    end
                end
            end else begin
                if (cnt != 16'd0) begin
                    r.cnt = cnt - 16'd1;
                end else begin
                    r.out  = ~out;
                    r.rise = ~out;
                    r.cnt  = lat;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/timer_noise_sound_generator.sv
// Top level of the timer and noise sound generator: register file, sequencer,
// shared timer step and sample adder. Depends on tnsg_pkg, tnsg_div, defines.
//
//  channel  direction  handshake                 payload
//  s_       in         s_valid / s_ready         s_command, s_offset, s_data
//  m_       out        m_valid / m_ready         m_sample
//  apb      in         psel, penable, pwrite     paddr, pwdata -> prdata
//
// A timer or effects write is done in its accepting cycle. A tick runs through the
// accepting cycle, then its sequencer steps (fraction, two noise steps, three timer steps
// through the shared timer unit, three music steps through the shared adder,
// result); with timer 0 held the noise and timer steps are skipped.
// A divider high-byte write of a nonzero count waits until the serial divider is done.
// Reset is synchronous and active low. A finished sample waits in the output
// register; a further tick stalls in its last step until that one is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_noise_sound_generator_defines.svh"
module timer_noise_sound_generator
    import tnsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [2:0]  s_offset,
    input  wire logic [7:0]  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [14:0]      m_sample,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FRAC = 4'd1;
    localparam logic [3:0] S_NA   = 4'd2;
    localparam logic [3:0] S_T0   = 4'd3;
    localparam logic [3:0] S_NB   = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_T2   = 4'd6;
    localparam logic [3:0] S_MUS  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [23:0] frac_cfg_reg;
    logic        music_reg;

    logic [7:0]  tctrl_reg [3];
    logic        tout_reg  [3];
    logic [15:0] tlat_reg  [3];
    logic [15:0] tcnt_reg  [3];
    logic [12:0] vol_reg   [3];
    logic [2:0]  prescale_reg;
    logic [7:0]  msb_reg;
    logic [1:0]  fx_reg;
    logic [127:0] noise_reg;
    logic        prev_tap_reg;
    logic [23:0] clk_frac_reg;
    logic        tog_reg   [3];
    logic        den_reg   [3];
    logic [15:0] dcount_reg [3];
    logic [STEP_BITS-1:0] dstep_reg [3];
    logic [ACC_BITS-1:0]  dphase_reg [3];

    logic        eclk_reg;
    logic        nclk_reg;
    logic        edge0_reg;
    logic [1:0]  idx_reg;
    logic [14:0] sum_reg;
    logic        mv_reg;
    logic [14:0] ms_reg;

    logic        in_fire, out_fire, cfg_wr;
    logic [1:0]  tsel;
    logic        tn, noisy, fb, nrise;
    logic [3:0]  ptot;
    tmr_res_t    tres;
    logic [14:0] addend;
    logic [ACC_BITS-1:0] phase_sum;
    logic [15:0] new_count;
    logic        div_start;
    div_stat_t   dstat;
    logic [STEP_BITS-1:0] quot;
    logic [1:0]  dch_reg;
    logic [24:0] frac_sum;
    logic [1:0]  lat_ch;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = mv_reg;
    assign m_sample = ms_reg;
    assign out_fire = mv_reg && m_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_MUSIC) ? {31'd0, music_reg} : {8'd0, frac_cfg_reg};

    assign noisy = ~(tctrl_reg[0][TC_ECLK] & tctrl_reg[1][TC_ECLK] & tctrl_reg[2][TC_ECLK]);
    assign fb    = noise_reg[127] ^ noise_reg[95];
    // A tap edge: bits 65..64 read 0,1 after the shift.
    assign nrise = !noise_reg[64] && noise_reg[63];
    assign frac_sum = {1'b0, clk_frac_reg} + {1'b0, frac_cfg_reg};

    always_comb begin
        unique case (state_reg)
            S_T1:    tsel = 2'd1;
            S_T2:    tsel = 2'd2;
            default: tsel = 2'd0;
        endcase
    end

    assign ptot = {1'b0, prescale_reg} + {3'd0, tn};

    always_comb begin
        logic nsrc;
        nsrc = tctrl_reg[tsel][TC_ECLK] ? eclk_reg : nclk_reg;
        tn   = nsrc;
        tres = tmr_step(tctrl_reg[tsel], tcnt_reg[tsel], tlat_reg[tsel], tout_reg[tsel],
                        (tsel == 2'd2 && tctrl_reg[2][TC_HOLD]) ? ptot[3] : nsrc);
    end

    assign phase_sum = dphase_reg[idx_reg] + dstep_reg[idx_reg][ACC_BITS-1:0];

    // Shared sample adder input for the current step.
    always_comb begin
        addend = 15'd0;
        unique case (state_reg)
            S_T0: if (tctrl_reg[0][TC_OUTEN] && tres.out && !fx_reg[1]) begin
                addend = {2'd0, vol_reg[0]};
            end
            S_T1, S_T2: if (tctrl_reg[tsel][TC_OUTEN] && tres.out) begin
                addend = {2'd0, vol_reg[tsel]};
            end
            S_MUS: if (music_reg && den_reg[idx_reg] && phase_sum[ACC_BITS-1]) begin
                addend = BASE_VOL;
            end
            default: addend = 15'd0;
        endcase
    end

    assign new_count = {s_data, dcount_reg[s_offset[1:0]][7:0]};
    assign div_start = in_fire && s_command == CMD_DIVIDER && s_offset < 3'd3
                       && tog_reg[s_offset[1:0]] && new_count != 16'd0;
    assign lat_ch = 2'(({1'b0, s_offset} - 4'd3) >> 1);

    tnsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (new_count),
        .stat     (dstat),
        .quotient (quot)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                if (s_command == CMD_TICK) begin
                    state_next = S_FRAC;
                end else if (div_start) begin
                    state_next = S_DIV;
                end
            end
            S_FRAC: state_next = tctrl_reg[0][TC_HOLD] ? S_MUS : S_NA;
            S_NA:   state_next = S_T0;
            S_T0:   state_next = S_NB;
            S_NB:   state_next = S_T1;
            S_T1:   state_next = S_T2;
            S_T2:   state_next = S_MUS;
            S_MUS:  if (idx_reg == 2'd2) state_next = S_OUT;
            S_OUT:  if (!mv_reg || m_ready) state_next = S_IDLE;
            S_DIV:  if (dstat.done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            frac_cfg_reg <= 24'h800000;
            music_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                tctrl_reg[i]  <= '0;
                tout_reg[i]   <= 1'b0;
                tlat_reg[i]   <= '0;
                tcnt_reg[i]   <= '0;
                vol_reg[i]    <= '0;
                tog_reg[i]    <= 1'b0;
                den_reg[i]    <= 1'b0;
                dcount_reg[i] <= '0;
                dstep_reg[i]  <= '0;
                dphase_reg[i] <= '0;
            end
            prescale_reg <= '0;
            msb_reg      <= '0;
            fx_reg       <= '0;
            noise_reg    <= '1;
            prev_tap_reg <= 1'b0;
            clk_frac_reg <= '0;
            mv_reg       <= 1'b0;
            idx_reg      <= '0;
            dch_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && pready) begin
                if (paddr[2] == REG_MUSIC) begin
                    music_reg <= pwdata[0];
                end else begin
                    frac_cfg_reg <= pwdata[23:0];
                end
            end
            // In the output step the handover below decides the flag on its own.
            if (out_fire && state_reg != S_OUT) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (in_fire) begin
                    unique case (s_command)
                        CMD_TIMER: begin
                            if (s_offset == TMR_OFF_CTRL02) begin
                                if (tctrl_reg[1][TC_HOLD]) tctrl_reg[0] <= s_data;
                                else tctrl_reg[2] <= s_data;
                            end else if (s_offset == TMR_OFF_CTRL1) begin
                                tctrl_reg[1] <= s_data;
                            end else if (!s_offset[0]) begin
                                msb_reg <= s_data;
                            end else begin
                                tlat_reg[lat_ch] <= {msb_reg, s_data};
                                if (!tctrl_reg[lat_ch][TC_NOLOAD]) begin
                                    tcnt_reg[lat_ch] <= {msb_reg, s_data};
                                end
                            end
                        end
                        CMD_DIVIDER: begin
                            if (s_offset < 3'd3) begin
                                tog_reg[s_offset[1:0]] <= ~tog_reg[s_offset[1:0]];
                                if (!tog_reg[s_offset[1:0]]) begin
                                    dcount_reg[s_offset[1:0]][7:0] <= s_data;
                                end else begin
                                    dcount_reg[s_offset[1:0]] <= new_count;
                                    dch_reg <= s_offset[1:0];
                                    if (new_count == 16'd0) begin
                                        dstep_reg[s_offset[1:0]] <= '0;
                                    end
                                end
                            end else if (s_offset == DIV_OFF_ENABLE && s_data[7:6] != 2'd3) begin
                                den_reg[s_data[7:6]] <= (s_data[3:1] != 3'd0);
                            end
                        end
                        CMD_EFFECTS: begin
                            if (s_offset == FX_OFF_CONTROL) begin
                                fx_reg <= s_data[1:0];
                            end else if (s_offset <= 3'd3) begin
                                vol_reg[2'(s_offset - 3'd1)] <= vol_of(s_data[2:0]);
                            end
                        end
                        default: begin
                            sum_reg  <= '0;
                            nclk_reg <= 1'b0;
                            edge0_reg <= 1'b0;
                            idx_reg  <= '0;
                        end
                    endcase
                end
                S_FRAC: begin
                    clk_frac_reg <= frac_sum[23:0];
                    eclk_reg     <= frac_sum[24];
                end
                S_NA: if (noisy && !fx_reg[0] && eclk_reg) begin
                    noise_reg    <= {noise_reg[126:0], fb ^ prev_tap_reg};
                    prev_tap_reg <= fb;
                    nclk_reg     <= nrise;
                end
                S_NB: if (noisy && fx_reg[0]) begin
                    nclk_reg <= 1'b0;
                    if (edge0_reg) begin
                        noise_reg    <= {noise_reg[126:0], fb ^ prev_tap_reg};
                        prev_tap_reg <= fb;
                        nclk_reg     <= nrise;
                    end
                end
                S_T0, S_T1, S_T2: if (tctrl_reg[tsel][TC_OUTEN]) begin
                    tcnt_reg[tsel] <= tres.cnt;
                    tout_reg[tsel] <= tres.out;
                    sum_reg        <= sum_reg + addend;
                    if (state_reg == S_T0) edge0_reg <= tres.rise;
                    if (state_reg == S_T2 && tctrl_reg[2][TC_HOLD]) begin
                        prescale_reg <= ptot[2:0];
                    end
                end
                S_MUS: begin
                    if (music_reg && den_reg[idx_reg]) begin
                        dphase_reg[idx_reg] <= phase_sum;
                    end
                    sum_reg <= sum_reg + addend;
                    idx_reg <= idx_reg + 2'd1;
                end
                S_OUT: if (!mv_reg || m_ready) begin
                    mv_reg <= 1'b1;
                    ms_reg <= sum_reg;
                end
                S_DIV: if (dstat.done) begin
                    dstep_reg[dch_reg] <= quot;
                end
                default: ;
            endcase
        end
    end

    `TNSG_ASSERT(a_ready_idle, aclk, aresetn, (state_reg != S_IDLE) |-> !s_ready,
        "input taken while busy")
    `TNSG_ASSERT(a_tick_start, aclk, aresetn, (in_fire && s_command == CMD_TICK) |=>
        (state_reg == S_FRAC), "tick did not start the sequence")
    `TNSG_ASSERT(a_div_wait, aclk, aresetn, dstat.done |-> (state_reg == S_DIV),
        "divider finished outside its wait step")
    `TNSG_ASSERT(a_result_from_tick, aclk, aresetn, $rose(mv_reg) |-> $past(state_reg == S_OUT),
        "result raised outside the output step")
    `TNSG_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !mv_reg, "result left after reset")

endmodule
`default_nettype wire

### hdl/tnsg_div.sv
// Serial restoring divider giving floor(2^ACC_BITS / divisor), one bit a cycle.
// Depends on tnsg_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_noise_sound_generator_defines.svh"
module tnsg_div
    import tnsg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [15:0]          divisor,
    output div_stat_t                 stat,
    output logic      [STEP_BITS-1:0] quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [16:0]             rem_reg, rem_next;
    logic [15:0]             dvs_reg, dvs_next;
    logic [STEP_BITS-1:0]    q_reg, q_next;
    logic [16:0]             trial;
    logic                    num_bit;

    // The dividend is a single one at the top followed by zeros.
    assign num_bit = (cnt_reg == DIV_CNT_BITS'(STEP_BITS));
    assign trial   = {rem_reg[15:0], num_bit};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(STEP_BITS);
            rem_next  = 17'd0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[STEP_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[STEP_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

    `TNSG_ASSERT(a_start_busy, aclk, aresetn, start |=> busy_reg, "divider did not start")
    `TNSG_ASSERT(a_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg), "stray done")
    `TNSG_ASSERT(a_idle_count, aclk, aresetn, (busy_reg && !start) |-> (cnt_reg != '0),
        "divider count ran out while busy")

endmodule
`default_nettype wire

### test/timer_noise_sound_generator_test.sv
// Self-checking testbench for the timer and noise sound generator.
// Depends on tnsg_pkg and the timer_noise_sound_generator RTL.
`timescale 1ns / 1ps
`default_nettype none

class sound_scoreboard;
    int unsigned errors;
    // Configuration as last written.
    bit [23:0]   frac_step;
    bit          music_on;
    // Block state mirrored at the block's widths.
    bit [7:0]    tctrl [3];
    bit          tout  [3];
    bit [2:0]    prescale;
    bit [15:0]   tlatch [3];
    bit [15:0]   tcount [3];
    bit [12:0]   volume [3];
    bit [7:0]    msb_hold;
    bit [1:0]    fx_ctrl;
    bit [127:0]  noise;
    bit          noise_tap;
    bit [23:0]   frac_acc;
    bit          div_toggle [3];
    bit          div_en [3];
    bit [15:0]   div_count [3];
    bit [24:0]   div_step [3];
    bit [23:0]   div_phase [3];
    bit [14:0]   samples_due [$];

    function new();
        errors    = 0;
        frac_step = 24'd8388608;
        music_on  = 1'b0;
        prescale  = '0;
        msb_hold  = '0;
        fx_ctrl   = '0;
        noise     = '1;
        noise_tap = 1'b0;
        frac_acc  = '0;
        for (int k = 0; k < 3; k++) begin
            tctrl[k] = '0; tout[k] = 0; tlatch[k] = '0; tcount[k] = '0;
            volume[k] = '0; div_toggle[k] = 0; div_en[k] = 0;
            div_count[k] = '0; div_step[k] = '0; div_phase[k] = '0;
        end
    endfunction

    function void set_reg(bit idx, bit [31:0] value);
        if (idx == tnsg_pkg::REG_FRAC) frac_step = value[23:0];
        else music_on = value[0];
    endfunction

    // Advances one timer channel n times and returns its rising edges.
    function int unsigned clock_timer(int ch, int unsigned n);
        int unsigned edges, lo, hi, cnt, lat;
        edges = 0;
        cnt = tcount[ch];
        lat = tlatch[ch];
        if (tctrl[ch][2]) begin
            lo = cnt & 8'hff;
            hi = cnt >> 8;
            while (n > lo) begin
                n -= lo + 1;
                lo = lat & 8'hff;
                if (hi == 0) begin
                    tout[ch] = 0;
                    hi = lat >> 8;
                end else begin
                    hi--;
                    if (hi == 0) begin
                        tout[ch] = 1;
                        edges++;
                    end
                end
            end
            lo = (lo - n) & 8'hff;
            cnt = (hi << 8) | lo;
        end else begin
            while (n > cnt) begin
                n -= cnt + 1;
                tout[ch] = ~tout[ch];
                edges += tout[ch];
                cnt = lat;
            end
            cnt = (cnt - n) & 16'hffff;
        end
        tcount[ch] = cnt[15:0];
        return edges;
    endfunction

    function int unsigned shift_noise(int unsigned n);
        int unsigned edges;
        bit fb;
        edges = 0;
        for (int i = 0; i < n; i++) begin
            fb = noise[127] ^ noise[95];
            noise = {noise[126:0], fb ^ noise_tap};
            noise_tap = fb;
            if (noise[65:64] == 2'b01) edges++;
        end
        return edges;
    endfunction

    function bit [14:0] sample_of_tick();
        int unsigned sum, eclk, nclk, e0, n;
        bit [24:0] acc;
        bit noisy;
        sum = 0;
        acc = frac_acc + frac_step;
        eclk = acc[24];
        frac_acc = acc[23:0];
        if (!tctrl[0][0]) begin
            noisy = (tctrl[0][1] & tctrl[1][1] & tctrl[2][1]) == 0;
            nclk = 0;
            e0 = 0;
            if (noisy && !fx_ctrl[0]) nclk = shift_noise(eclk);
            if (tctrl[0][7]) begin
                n = tctrl[0][1] ? eclk : nclk;
                e0 = clock_timer(0, n);
                if (tout[0] && !fx_ctrl[1]) sum += volume[0];
            end
            if (noisy && fx_ctrl[0]) nclk = shift_noise(e0);
            if (tctrl[1][7]) begin
                n = tctrl[1][1] ? eclk : nclk;
                void'(clock_timer(1, n));
                if (tout[1]) sum += volume[1];
            end
            if (tctrl[2][7]) begin
                n = tctrl[2][1] ? eclk : nclk;
                if (tctrl[2][0]) begin
                    n += prescale;
                    prescale = 3'(n & 7);
                    n >>= 3;
                end
                void'(clock_timer(2, n));
                if (tout[2]) sum += volume[2];
            end
        end
        if (music_on) begin
            for (int k = 0; k < 3; k++) begin
                if (div_en[k]) begin
                    div_phase[k] = div_phase[k] + div_step[k][23:0];
                    if (div_phase[k][23]) sum += tnsg_pkg::BASE_VOL;
                end
            end
        end
        return sum[14:0];
    endfunction

    // Notes an accepted input transaction and, for a tick, queues the sample it causes.
    function void note_input(bit [1:0] cmd, bit [2:0] off, bit [7:0] data);
        int ch;
        case (cmd)
            tnsg_pkg::CMD_TICK: samples_due.push_back(sample_of_tick());
            tnsg_pkg::CMD_TIMER: begin
                if (off == tnsg_pkg::TMR_OFF_CTRL02) begin
                    if (tctrl[1][0]) tctrl[0] = data;
                    else tctrl[2] = data;
                end else if (off == tnsg_pkg::TMR_OFF_CTRL1) begin
                    tctrl[1] = data;
                end else if (!off[0]) begin
                    msb_hold = data;
                end else begin
                    ch = (off - 3) >> 1;
                    tlatch[ch] = {msb_hold, data};
                    if (!tctrl[ch][4]) tcount[ch] = tlatch[ch];
                end
            end
            tnsg_pkg::CMD_DIVIDER: begin
                if (off < 3) begin
                    if (!div_toggle[off]) begin
                        div_toggle[off] = 1;
                        div_count[off][7:0] = data;
                    end else begin
                        div_toggle[off] = 0;
                        div_count[off][15:8] = data;
                        div_step[off] = (div_count[off] != 0) ?
                            25'((64'd1 << 24) / div_count[off]) : '0;
                    end
                end else if (off == tnsg_pkg::DIV_OFF_ENABLE) begin
                    if (data[7:6] != 2'd3) div_en[data[7:6]] = (data & 8'h0e) != 0;
                end
            end
            default: begin
                if (off == tnsg_pkg::FX_OFF_CONTROL) fx_ctrl = data[1:0];
                else if (off <= 3) volume[off - 1] = 13'((data[2:0] * 5461) / 7);
            end
        endcase
    endfunction

    function void check_sample(bit [14:0] got);
        bit [14:0] want;
        if (samples_due.size() == 0) begin
            $display("%0t: unexpected sample %0d", $time, got);
            errors++;
        end else begin
            want = samples_due.pop_front();
            if (want !== got) begin
                $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        end
    endfunction
endclass

module timer_noise_sound_generator_test;
    import tnsg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [2:0]  s_offset = '0;
    logic [7:0]  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [14:0] m_sample;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sound_scoreboard sb = new();
    int unsigned cycles = 0;
    int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both lightly

    timer_noise_sound_generator DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random back-pressure and checking of each transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_sample(m_sample);
            case (idle_mode)
                2: m_ready <= ($urandom_range(99) >= 84);
                3: m_ready <= ($urandom_range(99) >= 8);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [2:0] off,
                             input logic [7:0] data);
        int pct;
        pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 8 : 0;
        if ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_offset  <= off;
        s_data    <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, off, data);
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (sb.samples_due.size() != 0) @(posedge aclk);
        // Divider writes carry no result but keep the block busy for a while.
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_item();
        logic [1:0] cmd;
        logic [2:0] off;
        logic [7:0] data;
        off  = 3'($urandom_range(7));
        data = 8'($urandom_range(255));
        if ($urandom_range(99) < 55) begin
            cmd = CMD_TICK;
        end else begin
            cmd = 2'($urandom_range(3, 1));
            // Keep the timers mostly running and counts short so outputs toggle.
            if (cmd == CMD_TIMER && off <= 1 && $urandom_range(99) < 80) data[0] = off[0];
            if (cmd == CMD_TIMER && off >= 2 && !off[0] && $urandom_range(99) < 85)
                data = data & 8'h01;
            if (cmd == CMD_TIMER && off >= 3 && off[0] && $urandom_range(99) < 70)
                data = data & 8'h07;
        end
        send_item(cmd, off, data);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_FRAC, 32'h00ffffff);
        write_reg(REG_MUSIC, 32'd1);

        // Directed part: timer modes, volumes, dividers and ignored writes.
        send_item(CMD_TIMER, TMR_OFF_CTRL1, 8'h83);
        send_item(CMD_TIMER, TMR_OFF_CTRL02, 8'h82);
        send_item(CMD_TIMER, 3'd2, 8'h00);
        send_item(CMD_TIMER, 3'd3, 8'h02);
        send_item(CMD_TIMER, TMR_OFF_CTRL1, 8'h86);
        send_item(CMD_TIMER, 3'd5, 8'h01);
        send_item(CMD_TIMER, TMR_OFF_CTRL02, 8'h83);
        send_item(CMD_TIMER, 3'd7, 8'hff);
        send_item(CMD_EFFECTS, 3'd1, 8'hff);
        send_item(CMD_EFFECTS, 3'd2, 8'h03);
        send_item(CMD_EFFECTS, 3'd3, 8'h07);
        send_item(CMD_EFFECTS, 3'd6, 8'hff);
        send_item(CMD_DIVIDER, 3'd0, 8'h01);
        send_item(CMD_DIVIDER, 3'd0, 8'h00);
        send_item(CMD_DIVIDER, 3'd1, 8'h00);
        send_item(CMD_DIVIDER, 3'd1, 8'h00);
        send_item(CMD_DIVIDER, DIV_OFF_ENABLE, 8'h0e);
        send_item(CMD_DIVIDER, DIV_OFF_ENABLE, 8'hc2);
        send_item(CMD_DIVIDER, 3'd7, 8'h55);
        repeat (4) send_item(CMD_TICK, 3'd7, 8'hff);
        send_item(CMD_EFFECTS, FX_OFF_CONTROL, 8'h03);
        send_item(CMD_TICK, 3'd0, 8'h00);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(REG_FRAC, 32'hffffffff); write_reg(REG_MUSIC, 32'd1); end
                1: begin write_reg(REG_FRAC, 32'd0); write_reg(REG_MUSIC, 32'd0); end
                2: begin write_reg(REG_FRAC, $urandom); write_reg(REG_MUSIC, 32'd1); end
                default: begin
                    write_reg(REG_FRAC, 32'h00800000);
                    write_reg(REG_MUSIC, 32'hfffffffe);
                end
            endcase
            idle_mode = ph;
            for (int i = 0; i < 220; i++) begin
                random_item();
                if (i == 110) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (sb.samples_due.size() != 0);
                end
            end
            drain();
        end
        idle_mode = 0;
        drain();

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

### timer_noise_sound_generator.f
+incdir+hdl
hdl/tnsg_pkg.sv
hdl/tnsg_div.sv
hdl/timer_noise_sound_generator.sv
test/timer_noise_sound_generator_test.sv
